// File: src/ccif_pkg.sv
// ----------------------------------------------------------------------------
// ccif_pkg
// Shared types, constants and the intensity mapping of the changed-channel
// intensity framer.
// ----------------------------------------------------------------------------
package ccif_pkg;

  // channel store geometry
  localparam int unsigned CHANNELS = 4096;
  localparam int unsigned CH_AW    = $clog2(CHANNELS);

  // payload widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned LVL_W    = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PERIOD_W = 16;

  // input commands
  localparam logic [CMD_W-1:0] CMD_LEVEL     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FRAME_END = 2'd2;

  // packet kinds
  localparam logic KIND_INTENSITY = 1'b0;
  localparam logic KIND_HEARTBEAT = 1'b1;

  // packet bytes
  localparam logic [BYTE_W-1:0] PKT_SYNC       = 8'h00;
  localparam logic [BYTE_W-1:0] PKT_SET_INT    = 8'h03;
  localparam logic [BYTE_W-1:0] PKT_CH_BASE    = 8'h80;
  localparam logic [BYTE_W-1:0] HB_BYTE1       = 8'hFF;
  localparam logic [BYTE_W-1:0] HB_BYTE2       = 8'h81;
  localparam logic [BYTE_W-1:0] HB_BYTE3       = 8'h56;
  localparam logic [BYTE_W-1:0] UNIT_LIMIT     = 8'hF0;
  localparam logic [BYTE_W-1:0] INT_OFF        = 8'hF0;
  localparam logic [BYTE_W-1:0] INT_FULL       = 8'h01;
  localparam logic [BYTE_W-1:0] INT_BASE       = 8'd228;

  // byte positions of the final bytes
  localparam logic [2:0] INT_LAST_POS = 3'd5;
  localparam logic [2:0] HB_LAST_POS  = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd300;
  localparam logic [PERIOD_W-1:0] TICKS_SAT    = 16'hFFFF;

  // packet request from the update stage to the serializer
  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] intensity;
  } pkt_req_t;

  // percent rounded half up, t = floor((200*v + 255) / 510), then mapped;
  // n / 510 is (n >> 1) / 255 and x / 255 is (x + (x >> 8) + 1) >> 8 here
  function automatic logic [BYTE_W-1:0] map_intensity(input logic [LVL_W-1:0] v);
    logic [15:0] n;
    logic [14:0] m;
    logic [15:0] s;
    logic [6:0]  t;
    n = 16'(v) * 16'd200 + 16'd255;
    m = n[15:1];
    s = 16'(m) + 16'(m[14:8]) + 16'd1;
    t = s[14:8];
    if (t == 7'd0) begin
      map_intensity = INT_OFF;
    end else if (t == 7'd100) begin
      map_intensity = INT_FULL;
    end else begin
      map_intensity = INT_BASE - {t, 1'b0};
    end
  endfunction

endpackage

// File: src/ccif_if.sv
// ----------------------------------------------------------------------------
// ccif channel interfaces
// Valid/ready channels for level items, output bytes and the period register.
// ----------------------------------------------------------------------------
interface ccif_in_if;
  logic                         valid;
  logic                         ready;
  logic [ccif_pkg::CMD_W-1:0]   command;
  logic [ccif_pkg::IDX_W-1:0]   channel_index;
  logic [ccif_pkg::LVL_W-1:0]   level;
  modport source(output valid, command, channel_index, level, input ready);
  modport sink(input valid, command, channel_index, level, output ready);
endinterface

interface ccif_out_if;
  logic                         valid;
  logic                         ready;
  logic [ccif_pkg::BYTE_W-1:0]  tx_byte;
  logic                         packet_kind;
  logic                         last_byte;
  modport source(output valid, tx_byte, packet_kind, last_byte, input ready);
  modport sink(input valid, tx_byte, packet_kind, last_byte, output ready);
endinterface

interface ccif_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ccif_pkg::PERIOD_W-1:0] heartbeat_period;
  modport source(output valid, heartbeat_period, input ready);
  modport sink(input valid, heartbeat_period, output ready);
endinterface

// File: src/ccif_level_ram.sv
// ----------------------------------------------------------------------------
// ccif_level_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ccif_level_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/ccif_serializer.sv
// ----------------------------------------------------------------------------
// ccif_serializer
// Holds one packet and sends it one byte per item on the output channel.
// ----------------------------------------------------------------------------
module ccif_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ccif_pkg::pkt_req_t req,
  output logic               can_load,
  ccif_out_if.source         out_chan
);

  logic                          busy_r, busy_nxt;
  logic [2:0]                    pos_r, pos_nxt;
  logic                          kind_r;
  logic [ccif_pkg::BYTE_W-1:0]   unit_r;
  logic [ccif_pkg::BYTE_W-1:0]   int_r;
  logic [3:0]                    nib_r;
  logic [ccif_pkg::BYTE_W-1:0]   unit_calc;
  logic                          last;
  logic                          take;

  // unit number: index / 16, plus one below the limit
  always_comb begin
    unit_calc = req.idx[ccif_pkg::IDX_W-1:4];
    if (unit_calc < ccif_pkg::UNIT_LIMIT) begin
      unit_calc = unit_calc + 8'd1;
    end
  end

  assign last = (kind_r == ccif_pkg::KIND_HEARTBEAT) ? (pos_r == ccif_pkg::HB_LAST_POS)
                                                     : (pos_r == ccif_pkg::INT_LAST_POS);
  assign take     = busy_r && out_chan.ready;
  assign can_load = !busy_r || (take && last);

  // byte counter and busy flag
  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = 3'd0;
    end else if (take) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // packet payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= req.kind;
      unit_r <= unit_calc;
      int_r  <= req.intensity;
      nib_r  <= req.idx[3:0];
    end
  end

  // byte select
  always_comb begin
    out_chan.tx_byte = ccif_pkg::PKT_SYNC;
    if (kind_r == ccif_pkg::KIND_HEARTBEAT) begin
      case (pos_r)
        3'd1:    out_chan.tx_byte = ccif_pkg::HB_BYTE1;
        3'd2:    out_chan.tx_byte = ccif_pkg::HB_BYTE2;
        3'd3:    out_chan.tx_byte = ccif_pkg::HB_BYTE3;
        default: out_chan.tx_byte = ccif_pkg::PKT_SYNC;
      endcase
    end else begin
      case (pos_r)
        3'd1:    out_chan.tx_byte = unit_r;
        3'd2:    out_chan.tx_byte = ccif_pkg::PKT_SET_INT;
        3'd3:    out_chan.tx_byte = int_r;
        3'd4:    out_chan.tx_byte = ccif_pkg::PKT_CH_BASE | {4'd0, nib_r};
        default: out_chan.tx_byte = ccif_pkg::PKT_SYNC;
      endcase
    end
  end

  assign out_chan.valid       = busy_r;
  assign out_chan.packet_kind = kind_r;
  assign out_chan.last_byte   = last;

endmodule

// File: src/changed_channel_intensity_framer.sv
// ----------------------------------------------------------------------------
// changed_channel_intensity_framer
// Compares channel levels with a stored copy and frames intensity and
// heartbeat packets as a byte stream.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-entry level memory to zero, one entry
// per cycle, and no item is accepted until the sweep ends (period writes
// are taken at once). An item is accepted, its channel's last level is read
// from the memory in that cycle and compared in the next cycle, with the
// previous write forwarded when it hit the same channel. Unchanged levels,
// ticks and frame ends that send nothing go through at one item per cycle.
// A changed level sends six bytes and a heartbeat five, through the output
// serializer that sends one byte per cycle while out_chan is ready; the next
// packet is loaded in the cycle its predecessor's last byte is taken.
// ----------------------------------------------------------------------------
module changed_channel_intensity_framer (
  input  logic       clk,
  input  logic       rst_n,
  ccif_in_if.sink    in_chan,
  ccif_out_if.source out_chan,
  ccif_cfg_if.sink   cfg_chan
);

  logic                           clearing_r, clearing_nxt;
  logic [ccif_pkg::CH_AW-1:0]     clr_addr_r, clr_addr_nxt;

  logic                           s1_valid_r, s1_valid_nxt;
  logic [ccif_pkg::CMD_W-1:0]     s1_cmd_r;
  logic [ccif_pkg::IDX_W-1:0]     s1_idx_r;
  logic [ccif_pkg::LVL_W-1:0]     s1_level_r;
  logic [ccif_pkg::BYTE_W-1:0]    s1_int_r;

  logic                           fwd_valid_r, fwd_valid_nxt;
  logic [ccif_pkg::CH_AW-1:0]     fwd_addr_r;
  logic [ccif_pkg::LVL_W-1:0]     fwd_data_r;

  logic [ccif_pkg::PERIOD_W-1:0]  period_r, period_nxt;
  logic [ccif_pkg::PERIOD_W-1:0]  ticks_r, ticks_nxt;

  logic                           in_take;
  logic                           in_range;
  logic [ccif_pkg::LVL_W-1:0]     prev_level;
  logic                           hb_due;
  logic                           need_pkt;
  logic                           s1_adv;
  logic                           lvl_write;
  logic                           ser_load;
  logic                           ser_can_load;
  ccif_pkg::pkt_req_t             req;

  logic                           ram_we;
  logic [ccif_pkg::CH_AW-1:0]     ram_waddr;
  logic [ccif_pkg::LVL_W-1:0]     ram_wdata;
  logic [ccif_pkg::LVL_W-1:0]     ram_rdata;

  // input handshake
  assign in_chan.ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_take       = in_chan.valid && in_chan.ready;

  // period register
  assign cfg_chan.ready = 1'b1;
  assign period_nxt     = cfg_chan.valid ? cfg_chan.heartbeat_period : period_r;

  // clearing sweep after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + ccif_pkg::CH_AW'(1);
      if (clr_addr_r == ccif_pkg::CH_AW'(ccif_pkg::CHANNELS - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  // compare stage
  always_comb begin
    in_range   = {1'b0, s1_idx_r} < (ccif_pkg::IDX_W + 1)'(ccif_pkg::CHANNELS);
    prev_level = (fwd_valid_r && fwd_addr_r == s1_idx_r[ccif_pkg::CH_AW-1:0]) ? fwd_data_r
                                                                             : ram_rdata;
    hb_due     = ticks_r >= period_r;
    need_pkt   = 1'b0;
    req.kind   = ccif_pkg::KIND_INTENSITY;
    case (s1_cmd_r)
      ccif_pkg::CMD_LEVEL: begin
        need_pkt = in_range && (prev_level != s1_level_r);
      end
      ccif_pkg::CMD_FRAME_END: begin
        need_pkt = hb_due;
        req.kind = ccif_pkg::KIND_HEARTBEAT;
      end
      default: begin
        need_pkt = 1'b0;
      end
    endcase
    req.idx       = s1_idx_r;
    req.intensity = s1_int_r;
    s1_adv        = s1_valid_r && (!need_pkt || ser_can_load);
    ser_load      = s1_valid_r && need_pkt && ser_can_load;
    lvl_write     = ser_load && (s1_cmd_r == ccif_pkg::CMD_LEVEL);
    s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  end

  // heartbeat counter
  always_comb begin
    ticks_nxt = ticks_r;
    if (s1_adv) begin
      case (s1_cmd_r)
        ccif_pkg::CMD_TICK: begin
          if (ticks_r != ccif_pkg::TICKS_SAT) begin
            ticks_nxt = ticks_r + 16'd1;
          end
        end
        ccif_pkg::CMD_FRAME_END: begin
          if (hb_due) begin
            ticks_nxt = '0;
          end
        end
        default: begin
          ticks_nxt = ticks_r;
        end
      endcase
    end
  end

  // memory write: sweep or level update
  assign ram_we        = clearing_r || lvl_write;
  assign ram_waddr     = clearing_r ? clr_addr_r : s1_idx_r[ccif_pkg::CH_AW-1:0];
  assign ram_wdata     = clearing_r ? '0 : s1_level_r;
  assign fwd_valid_nxt = fwd_valid_r || lvl_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      period_r    <= ccif_pkg::PERIOD_RESET;
      ticks_r     <= ccif_pkg::TICKS_SAT;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      period_r    <= period_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

  // stage payload and forwarding copy of the last write
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r   <= in_chan.command;
      s1_idx_r   <= in_chan.channel_index;
      s1_level_r <= in_chan.level;
      s1_int_r   <= ccif_pkg::map_intensity(in_chan.level);
    end
    if (lvl_write) begin
      fwd_addr_r <= s1_idx_r[ccif_pkg::CH_AW-1:0];
      fwd_data_r <= s1_level_r;
    end
  end

  ccif_level_ram #(
    .WIDTH (ccif_pkg::LVL_W),
    .DEPTH (ccif_pkg::CHANNELS)
  ) u_level_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_take),
    .raddr (in_chan.channel_index[ccif_pkg::CH_AW-1:0]),
    .rdata (ram_rdata)
  );

  ccif_serializer u_serializer (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ser_load),
    .req      (req),
    .can_load (ser_can_load),
    .out_chan (out_chan)
  );

  // a stalled compare stage keeps its item
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_idx_r) && $stable(s1_cmd_r))
    else $error("compare stage lost a stalled item");

  // no level update while the sweep runs
  a_no_update_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_valid_r && !lvl_write)
    else $error("level update during clearing sweep");

  // a sent heartbeat restarts the count
  a_hb_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ser_load && s1_cmd_r == ccif_pkg::CMD_FRAME_END |=> ticks_r == '0)
    else $error("heartbeat did not restart tick count");

  // a packet is loaded only when the serializer is free or finishing
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ser_load |-> !out_chan.valid || (out_chan.ready && out_chan.last_byte))
    else $error("packet loaded over an unsent one");

endmodule
